@@ sv/safs_pkg.sv @@
// Package for the sorted address floor search unit.
// Holds default sizes, operation codes and the table control struct.
// No dependencies.
package safs_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ADDRESS_BITS = 32;
    localparam int NAME_BITS    = 16;

    localparam int INDEX_OUT_BITS = 10;
    localparam int NAME_OUT_BITS  = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctl;

endpackage

@@ sv/sorted_address_floor_search_unit.sv @@
// Clear and append complete in the idle state. A lookup on a non-empty table
// issues its first table read, then runs probe steps (one table read each,
// bounded by the registered read port) and loads the output register in the
// done state once the output is free; new transactions are accepted only in idle.
// Reset clears the entry count and the output valid; table contents are kept.
// Top level: instantiates safs_ctrl and safs_table. Uses safs_pkg.
module sorted_address_floor_search_unit #(
    parameter int TABLE_DEPTH  = safs_pkg::TABLE_DEPTH,
    parameter int ADDRESS_BITS = safs_pkg::ADDRESS_BITS,
    parameter int NAME_BITS    = safs_pkg::NAME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_operation,
    input  logic [ADDRESS_BITS-1:0]             i_entry_address,
    input  logic [NAME_BITS-1:0]                i_entry_name,
    input  logic [ADDRESS_BITS-1:0]             i_query_address,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [safs_pkg::INDEX_OUT_BITS-1:0] o_entry_index,
    output logic [safs_pkg::NAME_OUT_BITS-1:0]  o_name_offset
);

    localparam int IW = $clog2(TABLE_DEPTH);

    safs_pkg::t_tbl_ctl      tbl_ctl;
    logic [IW-1:0]           wr_addr;
    logic [IW-1:0]           rd_addr;
    logic [ADDRESS_BITS-1:0] rd_start;
    logic [NAME_BITS-1:0]    rd_name;

    safs_ctrl #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDRESS_BITS),
        .NAME_W (NAME_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_query_address (i_query_address),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_entry_index   (o_entry_index),
        .o_name_offset   (o_name_offset),
        .o_ctl           (tbl_ctl),
        .o_wr_addr       (wr_addr),
        .o_rd_addr       (rd_addr),
        .i_rd_start      (rd_start),
        .i_rd_name       (rd_name)
    );

    safs_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDRESS_BITS),
        .NAME_W (NAME_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_ctl      (tbl_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_start (i_entry_address),
        .i_wr_name  (i_entry_name),
        .i_rd_addr  (rd_addr),
        .o_rd_start (rd_start),
        .o_rd_name  (rd_name)
    );

endmodule

@@ sv/safs_table.sv @@
// Entry table: start address memory and name offset memory.
// One write port and one shared registered read port. Uses safs_pkg.
module safs_table #(
    parameter int DEPTH  = safs_pkg::TABLE_DEPTH,
    parameter int ADDR_W = safs_pkg::ADDRESS_BITS,
    parameter int NAME_W = safs_pkg::NAME_BITS,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  safs_pkg::t_tbl_ctl i_ctl,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [ADDR_W-1:0] i_wr_start,
    input  logic [NAME_W-1:0] i_wr_name,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [ADDR_W-1:0] o_rd_start,
    output logic [NAME_W-1:0] o_rd_name
);

    logic [ADDR_W-1:0] r_mem_start [DEPTH];
    logic [NAME_W-1:0] r_mem_name  [DEPTH];
    logic [ADDR_W-1:0] r_rd_start;
    logic [NAME_W-1:0] r_rd_name;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_start[i_wr_addr] <= i_wr_start;
            r_mem_name[i_wr_addr]  <= i_wr_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_start <= r_mem_start[i_rd_addr];
            r_rd_name  <= r_mem_name[i_rd_addr];
        end
    end

    assign o_rd_start = r_rd_start;
    assign o_rd_name  = r_rd_name;

endmodule

@@ sv/safs_ctrl.sv @@
// Search sequencer: entry count, binary search bounds and output register.
// Drives the table memory in safs_table. Uses safs_pkg.
module safs_ctrl #(
    parameter int DEPTH  = safs_pkg::TABLE_DEPTH,
    parameter int ADDR_W = safs_pkg::ADDRESS_BITS,
    parameter int NAME_W = safs_pkg::NAME_BITS,
    localparam int IW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_operation,
    input  logic [ADDR_W-1:0]                    i_query_address,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic [safs_pkg::INDEX_OUT_BITS-1:0]  o_entry_index,
    output logic [safs_pkg::NAME_OUT_BITS-1:0]   o_name_offset,
    output safs_pkg::t_tbl_ctl                   o_ctl,
    output logic [IW-1:0]                        o_wr_addr,
    output logic [IW-1:0]                        o_rd_addr,
    input  logic [ADDR_W-1:0]                    i_rd_start,
    input  logic [NAME_W-1:0]                    i_rd_name
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [ADDR_W-1:0] r_query, n_query;
    logic              r_hit, n_hit;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    logic [safs_pkg::INDEX_OUT_BITS-1:0] r_out_index, n_out_index;
    logic [safs_pkg::NAME_OUT_BITS-1:0]  r_out_name, n_out_name;

    logic [CW:0]   cur_sum;
    logic [CW-1:0] cur_mid;
    logic [CW-1:0] lo_nx, hi_nx;
    logic [CW:0]   nx_sum;
    logic [CW-1:0] lo_dec;
    logic [CW-1:0] idx;
    logic [31:0]   idx_wide;
    logic [31:0]   name_wide;
    logic          le;

    assign cur_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid  = cur_sum[CW:1];
    assign le       = (i_rd_start <= r_query);
    assign lo_nx    = le ? (cur_mid + CW'(1)) : r_lo;
    assign hi_nx    = le ? r_hi : cur_mid;
    assign nx_sum   = {1'b0, lo_nx} + {1'b0, hi_nx};
    assign lo_dec   = lo_nx - CW'(1);
    assign idx      = r_lo - CW'(1);
    assign idx_wide = 32'(idx);
    assign name_wide = 32'(i_rd_name);

    assign o_stall   = (r_state != ST_IDLE);
    assign o_wr_addr = r_count[IW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_query     = r_query;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_stall;
        n_out_hit   = r_out_hit;
        n_out_index = r_out_index;
        n_out_name  = r_out_name;
        o_ctl       = '0;
        o_rd_addr   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_operation)
                        safs_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        safs_pkg::OP_APPEND: begin
                            if (r_count < CW'(DEPTH)) begin
                                o_ctl.wr_en = 1'b1;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        safs_pkg::OP_LOOKUP: begin
                            n_query = i_query_address;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_hit   = 1'b0;
                            if (r_count != '0) begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = IW'(r_count >> 1);
                                n_state     = ST_PROBE;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROBE: begin
                n_lo = lo_nx;
                n_hi = hi_nx;
                if (lo_nx < hi_nx) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = IW'(nx_sum[CW:1]);
                end else begin
                    n_hit   = (lo_nx != '0);
                    n_state = ST_DONE;
                    if (lo_nx != '0) begin
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = lo_dec[IW-1:0];
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_index = r_hit ? idx_wide[safs_pkg::INDEX_OUT_BITS-1:0] : '0;
                    n_out_name  = r_hit ? name_wide[safs_pkg::NAME_OUT_BITS-1:0] : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_query     <= n_query;
        r_hit       <= n_hit;
        r_out_hit   <= n_out_hit;
        r_out_index <= n_out_index;
        r_out_name  <= n_out_name;
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_entry_index = r_out_index;
    assign o_name_offset = r_out_name;

endmodule

@@ verif/sorted_address_floor_search_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_address_floor_search_unit: directed, large-table and
// random table builds with lookups, each result checked against a local floor search.
// Depends on safs_pkg and the unit RTL.
module sorted_address_floor_search_unit_tb;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         ITEM_TARGET  = 750;
    localparam int         LARGE_FILL   = 300;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 30;

    typedef logic [safs_pkg::ADDRESS_BITS-1:0] t_addr;
    typedef logic [safs_pkg::NAME_BITS-1:0]    t_name;

    typedef struct packed {
        logic [1:0] op;
        t_addr      entry_address;
        t_name      entry_name;
        t_addr      query_address;
    } t_request;

    typedef struct packed {
        logic                                hit;
        logic [safs_pkg::INDEX_OUT_BITS-1:0] entry_index;
        logic [safs_pkg::NAME_OUT_BITS-1:0]  name_offset;
    } t_floor;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_valid         = 1'b0;
    logic                                o_stall;
    logic [1:0]                          i_operation     = safs_pkg::OP_CLEAR;
    t_addr                               i_entry_address = '0;
    t_name                               i_entry_name    = '0;
    t_addr                               i_query_address = '0;
    logic                                o_valid;
    logic                                i_stall         = 1'b0;
    logic                                o_hit;
    logic [safs_pkg::INDEX_OUT_BITS-1:0] o_entry_index;
    logic [safs_pkg::NAME_OUT_BITS-1:0]  o_name_offset;

    sorted_address_floor_search_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_entry_address (i_entry_address),
        .i_entry_name    (i_entry_name),
        .i_query_address (i_query_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_entry_index   (o_entry_index),
        .o_name_offset   (o_name_offset)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Local copy of the table
    t_addr    tbl_addr [safs_pkg::TABLE_DEPTH];
    t_name    tbl_name [safs_pkg::TABLE_DEPTH];
    int       entry_total = 0;
    int       peak_total  = 0;

    t_request pending_requests [$];
    t_floor   awaited_floors [$];
    int       issued         = 0;
    int       sent_count     = 0;
    int       lookups_seen   = 0;
    int       hits_seen      = 0;
    int       errors         = 0;
    int       cycle_count    = 0;

    function automatic t_floor floor_of(t_addr query);
        int     lo;
        int     hi;
        int     mid;
        t_floor found;
        lo = 0;
        hi = entry_total;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_addr[mid] <= query) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        found = '0;
        if (lo > 0) begin
            found.hit         = 1'b1;
            found.entry_index = safs_pkg::INDEX_OUT_BITS'(lo - 1);
            found.name_offset = tbl_name[lo - 1];
        end
        return found;
    endfunction

    function automatic void apply_request(t_request req);
        case (req.op)
            safs_pkg::OP_CLEAR: begin
                entry_total = 0;
            end
            safs_pkg::OP_APPEND: begin
                if (entry_total < safs_pkg::TABLE_DEPTH) begin
                    tbl_addr[entry_total] = req.entry_address;
                    tbl_name[entry_total] = req.entry_name;
                    entry_total++;
                    if (entry_total > peak_total) peak_total = entry_total;
                end
            end
            safs_pkg::OP_LOOKUP: begin
                awaited_floors.push_back(floor_of(req.query_address));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_request(logic [1:0] op, t_addr ea, t_name en, t_addr qa);
        t_request req;
        req.op            = op;
        req.entry_address = ea;
        req.entry_name    = en;
        req.query_address = qa;
        pending_requests.push_back(req);
        if (op != OP_UNUSED) issued++;
    endfunction

    function automatic void add_clear();
        add_request(safs_pkg::OP_CLEAR, $urandom, t_name'($urandom), $urandom);
    endfunction

    function automatic void add_append(t_addr ea, t_name en);
        add_request(safs_pkg::OP_APPEND, ea, en, $urandom);
    endfunction

    function automatic void add_lookup(t_addr qa);
        add_request(safs_pkg::OP_LOOKUP, $urandom, t_name'($urandom), qa);
    endfunction

    function automatic void add_noise();
        add_request(OP_UNUSED, $urandom, t_name'($urandom), $urandom);
    endfunction

    // Mostly short gaps, some long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Driver
    t_request cur_req;
    int       gap_left  = 0;
    bit       smooth_tx = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                apply_request(cur_req);
                sent_count++;
                gap_left = smooth_tx ? 0 : idle_span();
                if ($urandom_range(0, 63) == 0) smooth_tx = !smooth_tx;
            end
            if (gap_left != 0 || pending_requests.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                cur_req = pending_requests.pop_front();
                i_valid         <= 1'b1;
                i_operation     <= cur_req.op;
                i_entry_address <= cur_req.entry_address;
                i_entry_name    <= cur_req.entry_name;
                i_query_address <= cur_req.query_address;
            end
        end
    end

    // Monitor
    t_floor want;
    int     hold_left = 0;
    bit     smooth_rx = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_floors.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result hit=%0b index=%0d name=%h",
                             $time, o_hit, o_entry_index, o_name_offset);
                end else begin
                    want = awaited_floors.pop_front();
                    lookups_seen++;
                    if (want.hit) hits_seen++;
                    if (o_hit !== want.hit || o_entry_index !== want.entry_index ||
                        o_name_offset !== want.name_offset) begin
                        errors++;
                        $display({"%0t: result error, expected hit=%0b index=%0d name=%h,",
                                  " actual hit=%0b index=%0d name=%h"},
                                 $time, want.hit, want.entry_index, want.name_offset,
                                 o_hit, o_entry_index, o_name_offset);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                hold_left = smooth_rx ? 0 : idle_span();
                if ($urandom_range(0, 63) == 0) smooth_rx = !smooth_rx;
                if (hold_left != 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_addr       seq_addr [$];
        t_addr       a;
        t_addr       first_addr;
        int unsigned lim;
        int          k;
        int          m;
        int          j;
        int          sel;
        int          pick;
        bit          broken;

        // Directed: empty table, extremes, exact hits, noise, clear, out-of-order
        add_lookup('0);
        add_lookup('1);
        add_noise();
        add_append(32'h0000_0100, 16'hFFFF);
        add_append(32'h0000_0200, 16'h0000);
        add_append('1, 16'hA5A5);
        add_lookup('0);
        add_lookup(32'h0000_00FF);
        add_lookup(32'h0000_0100);
        add_lookup(32'h0000_01FF);
        add_lookup(32'h0000_0200);
        add_lookup(32'hFFFF_FFFE);
        add_lookup('1);
        add_noise();
        add_lookup(32'h0000_0150);
        add_clear();
        add_lookup('1);
        add_append('0, 16'h1234);
        add_lookup('0);
        add_append(32'h0000_0050, 16'h5A5A);
        add_append(32'h0000_0010, 16'h0F0F);
        add_lookup(32'h0000_0010);
        add_lookup(32'h0000_0050);
        add_lookup(32'h0000_0030);

        // Build a large ascending table, then probe its ends and stored addresses
        add_clear();
        seq_addr.delete();
        first_addr = $urandom_range(1, 16'hFFFF);
        a = first_addr;
        for (j = 0; j < LARGE_FILL; j++) begin
            if (j > 0) a = a + $urandom_range(1, 32'h003F_0000);
            seq_addr.push_back(a);
            add_append(a, t_name'($urandom));
        end
        add_lookup('1);
        add_lookup('0);
        add_lookup(first_addr - 1);
        add_lookup(first_addr);
        add_lookup(seq_addr[LARGE_FILL - 1]);
        add_lookup(seq_addr[LARGE_FILL - 1] + 1);
        for (j = 0; j < 12; j++) begin
            sel = $urandom_range(0, LARGE_FILL - 1);
            add_lookup(seq_addr[sel] + $urandom_range(0, 2) - 1);
        end

        // Random table builds with lookups aimed at the stored addresses
        while (issued < ITEM_TARGET) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            broken = ($urandom_range(0, 6) == 0);
            if (!broken || $urandom_range(0, 1) == 0) add_clear();
            lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : 32'hFFFF_FFFF / (k + 1);
            seq_addr.delete();
            a = $urandom_range(0, lim);
            for (j = 0; j < k; j++) begin
                if (j > 0) a = a + $urandom_range(0, lim);
                seq_addr.push_back(a);
                add_append(a, t_name'($urandom));
                if (broken && $urandom_range(0, 3) == 0) begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0) add_noise();
                    else if (pick == 1) add_append($urandom, t_name'($urandom));
                    else add_lookup($urandom);
                end
            end
            m = $urandom_range(2, 8);
            for (j = 0; j < m; j++) begin
                pick = $urandom_range(0, 9);
                if (seq_addr.size() != 0) sel = $urandom_range(0, seq_addr.size() - 1);
                if (seq_addr.size() == 0 || pick > 6) add_lookup($urandom);
                else if (pick == 0) add_lookup('0);
                else if (pick == 1) add_lookup('1);
                else if (pick <= 4) add_lookup(seq_addr[sel]);
                else if (pick == 5) add_lookup(seq_addr[sel] - 1);
                else add_lookup(seq_addr[sel] + 1);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid) @(negedge i_clk);
        while (awaited_floors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d transactions in %0d cycles; table grew to %0d entries at most.",
                 sent_count, cycle_count, peak_total);
        $display("Checked %0d lookups: %0d hits, %0d misses.",
                 lookups_seen, hits_seen, lookups_seen - hits_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sorted_address_floor_search_unit.f @@
sv/safs_pkg.sv
sv/safs_table.sv
sv/safs_ctrl.sv
sv/sorted_address_floor_search_unit.sv
verif/sorted_address_floor_search_unit_tb.sv
